### rtl/core/ehcr_pkg.sv
// Shared types and constants for the echo handshake command receiver.
package ehcr_pkg;

  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  // Type digit plus four fields of three digits.
  localparam logic [3:0] LAST_POS = 4'd12;
  localparam logic [1:0] LAST_DIGIT = 2'd2;

  localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] CFG_COLOR = 2'd1;
  localparam logic [1:0] CFG_LOOP = 2'd2;
  localparam logic [1:0] CFG_STOP = 2'd3;

  localparam logic [3:0] RST_CODE_BRIGHTNESS = 4'd1;
  localparam logic [3:0] RST_CODE_COLOR = 4'd2;
  localparam logic [3:0] RST_CODE_LOOP = 4'd3;
  localparam logic [3:0] RST_CODE_STOP = 4'd4;
  localparam logic [7:0] RST_BRIGHTNESS = 8'hFF;

  typedef struct packed {
    logic hold_char;
    logic append;
    logic clear_len;
    logic load_out;
    logic tx_held;
    logic parse_run;
    logic commit;
  } ehcr_cmd_t;

  typedef struct packed {
    logic is_s;
    logic is_e;
    logic is_a;
    logic parse_done;
  } ehcr_status_t;

endpackage

### rtl/core/echo_handshake_command_receiver_core.sv
// Top level of the echo handshake command receiver.
//
// Each input beat on rx_byte is one received character. The block runs the
// start, read, write and acknowledge handshake and answers with at most one
// result beat: the echoed character on tx_byte together with the current
// brightness, colour and animation settings and a settings_changed flag.
// A character that is not echoed produces no result beat.
// An ordinary character gives its result in the cycle after it is accepted,
// and a new character can be accepted every cycle while the output is taken.
// The release character runs a parse of the first thirteen stored
// characters from the message RAM, one read per cycle; the commit state then
// loads its result once the output is free, and the next character can be
// accepted back in the idle state. No input is taken meanwhile.
// A stalled result holds its value and the settings outputs do not change
// until it is taken; the next input is accepted in the cycle it leaves.
// Reset puts the handshake in the read phase, empties the message, sets
// full brightness, a black colour, animation off and the default type codes.
// The type code registers are written through cfg_write, cfg_index and cfg_data;
// the user must write them only while the block is idle, which the block does not enforce.
module echo_handshake_command_receiver_core #(
  parameter int MSG_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic [7:0] brightness,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] white,
  output logic       animate_on,
  output logic       settings_changed
);

  ehcr_pkg::ehcr_cmd_t    cmd;
  ehcr_pkg::ehcr_status_t st;
  logic [31:0]            color;

  ehcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ehcr_datapath #(
    .MSG_LEN(MSG_LEN)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rx_byte         (rx_byte),
    .cmd             (cmd),
    .st              (st),
    .tx_byte         (tx_byte),
    .brightness      (brightness),
    .color           (color),
    .animate_on      (animate_on),
    .settings_changed(settings_changed)
  );

  assign red   = color[31:24];
  assign green = color[23:16];
  assign blue  = color[15:8];
  assign white = color[7:0];

endmodule

### rtl/core/ehcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ehcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ehcr_ctrl.sv
// Controller: handshake phase, release sequencing and output valid.
module ehcr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ehcr_pkg::ehcr_status_t st,
  output ehcr_pkg::ehcr_cmd_t    cmd
);

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_READ  = 4'b0010,
    PH_WRITE = 4'b0100,
    PH_ACK   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PARSE  = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  phase_t phase, phase_next;
  state_t state, state_next;
  logic   can_load;
  logic   accept;

  assign can_load = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && can_load);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_next = phase;
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (phase)
            PH_START: begin
              if (st.is_s) begin
                cmd.clear_len = 1'b1;
                cmd.load_out  = 1'b1;
                phase_next    = PH_READ;
              end else if (st.is_e) begin
                cmd.load_out = 1'b1;
              end
            end
            PH_READ: begin
              cmd.load_out = 1'b1;
              if (!st.is_s) begin
                cmd.hold_char = 1'b1;
                phase_next    = PH_WRITE;
              end
            end
            PH_WRITE: begin
              if (st.is_a) begin
                cmd.append   = 1'b1;
                cmd.load_out = 1'b1;
                phase_next   = PH_ACK;
              end else if (st.is_e) begin
                cmd.append = 1'b1;
                phase_next = PH_START;
                state_next = ST_PARSE;
              end else begin
                cmd.load_out = 1'b1;
                cmd.tx_held  = 1'b1;
              end
            end
            PH_ACK: begin
              cmd.load_out = 1'b1;
              if (!st.is_a) begin
                cmd.hold_char = 1'b1;
                phase_next    = PH_WRITE;
              end
            end
            default: phase_next = PH_READ;
          endcase
        end
      end
      ST_PARSE: begin
        cmd.parse_run = 1'b1;
        if (st.parse_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (can_load) begin
          cmd.commit    = 1'b1;
          cmd.load_out  = 1'b1;
          cmd.clear_len = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_READ;
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      state     <= state_next;
      out_valid <= cmd.load_out || (out_valid && out_stall);
    end
  end

endmodule

### rtl/core/ehcr_datapath.sv
// Datapath: message store, field parser, settings and output registers.
module ehcr_datapath #(
  parameter int MSG_LEN = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  input  logic [7:0]             rx_byte,
  input  ehcr_pkg::ehcr_cmd_t    cmd,
  output ehcr_pkg::ehcr_status_t st,
  output logic [7:0]             tx_byte,
  output logic [7:0]             brightness,
  output logic [31:0]            color,
  output logic                   animate_on,
  output logic                   settings_changed
);

  localparam int AW = $clog2(MSG_LEN);
  localparam int LW = $clog2(MSG_LEN + 1);

  logic [3:0]    code_brightness, code_color, code_loop, code_stop;
  logic [7:0]    held_char;
  logic [LW-1:0] msg_len;
  logic          mem_we;
  logic [7:0]    mem_rdata;
  logic [3:0]    rd_pos;
  logic          dvalid;
  logic [3:0]    dpos;
  logic [3:0]    type_code;
  logic [1:0]    fld;
  logic [1:0]    dig_idx;
  logic [7:0]    acc;
  logic          stop_flag;
  logic [7:0]    fields [4];
  logic          avail, is_dig;
  logic [3:0]    dval;
  logic [7:0]    acc_base, acc_next;
  logic          stop_base, stop_next;
  logic          match;

  assign st.is_s       = (rx_byte == ehcr_pkg::CHAR_S);
  assign st.is_e       = (rx_byte == ehcr_pkg::CHAR_E);
  assign st.is_a       = (rx_byte == ehcr_pkg::CHAR_A);
  assign st.parse_done = dvalid && (dpos == ehcr_pkg::LAST_POS);

  assign mem_we = cmd.append && (msg_len < LW'(MSG_LEN));

  ehcr_ram #(
    .WIDTH(8),
    .DEPTH(MSG_LEN)
  ) u_msg_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(msg_len[AW-1:0]),
    .wdata(held_char),
    .raddr(AW'(rd_pos)),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_brightness <= ehcr_pkg::RST_CODE_BRIGHTNESS;
      code_color      <= ehcr_pkg::RST_CODE_COLOR;
      code_loop       <= ehcr_pkg::RST_CODE_LOOP;
      code_stop       <= ehcr_pkg::RST_CODE_STOP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ehcr_pkg::CFG_BRIGHTNESS: code_brightness <= cfg_data;
        ehcr_pkg::CFG_COLOR:      code_color <= cfg_data;
        ehcr_pkg::CFG_LOOP:       code_loop <= cfg_data;
        ehcr_pkg::CFG_STOP:       code_stop <= cfg_data;
        default:                  code_stop <= code_stop;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char <= '0;
      msg_len   <= '0;
    end else begin
      if (cmd.hold_char) begin
        held_char <= rx_byte;
      end
      if (cmd.clear_len) begin
        msg_len <= '0;
      end else if (mem_we) begin
        msg_len <= msg_len + LW'(1);
      end
    end
  end

  // Read sequencer: one stored character per cycle, data registered in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos <= '0;
      dvalid <= 1'b0;
    end else begin
      rd_pos <= (cmd.parse_run && rd_pos <= ehcr_pkg::LAST_POS) ? rd_pos + 4'd1 :
                (cmd.parse_run ? rd_pos : 4'd0);
      dvalid <= cmd.parse_run && (rd_pos <= ehcr_pkg::LAST_POS);
    end
  end

  always_ff @(posedge clk) begin
    dpos <= rd_pos;
  end

  assign avail  = LW'(dpos) < msg_len;
  assign is_dig = (mem_rdata >= ehcr_pkg::CHAR_0) && (mem_rdata <= ehcr_pkg::CHAR_9);
  assign dval   = 4'(mem_rdata - ehcr_pkg::CHAR_0);

  always_comb begin
    acc_base  = (dig_idx == 2'd0) ? 8'd0 : acc;
    stop_base = (dig_idx == 2'd0) ? 1'b0 : stop_flag;
    if (avail && is_dig && !stop_base) begin
      acc_next  = {acc_base[4:0], 3'b000} + {acc_base[6:0], 1'b0} + {4'b0000, dval};
      stop_next = stop_base;
    end else begin
      acc_next  = acc_base;
      stop_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dvalid) begin
      if (dpos == 4'd0) begin
        type_code <= (avail && is_dig) ? dval : 4'd0;
        fld       <= 2'd0;
        dig_idx   <= 2'd0;
      end else begin
        acc       <= acc_next;
        stop_flag <= stop_next;
        if (dig_idx == ehcr_pkg::LAST_DIGIT) begin
          fields[fld] <= acc_next;
          fld         <= fld + 2'd1;
          dig_idx     <= 2'd0;
        end else begin
          dig_idx <= dig_idx + 2'd1;
        end
      end
    end
  end

  assign match = (type_code == code_brightness) || (type_code == code_color) ||
                 (type_code == code_loop) || (type_code == code_stop);

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= ehcr_pkg::RST_BRIGHTNESS;
      color      <= '0;
      animate_on <= 1'b0;
    end else if (cmd.commit) begin
      priority if (type_code == code_brightness) begin
        brightness <= fields[0];
      end else if (type_code == code_color) begin
        color <= {fields[0], fields[1], fields[2], fields[3]};
      end else if (type_code == code_loop) begin
        animate_on <= 1'b1;
      end else if (type_code == code_stop) begin
        animate_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tx_byte          <= cmd.commit ? ehcr_pkg::CHAR_E :
                          (cmd.tx_held ? held_char : rx_byte);
      settings_changed <= cmd.commit && match;
    end
  end

endmodule
